/* hw/rtl/rppo_pkg.sv */
`timescale 1ns / 1ps

package rppo_pkg;

	typedef enum logic [2:0] {
		MODE_PASS,
		MODE_GRAY,
		MODE_NEG,
		MODE_BRIGHT,
		MODE_DARK,
		MODE_CONTRAST,
		MODE_BINARY,
		MODE_SEPIA
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE,
		REG_AMOUNT,
		REG_GAIN,
		REG_THRESH
	} reg_idx_t;

	localparam int AddrW = 4;
	localparam int DataW = 32;

	localparam logic [9:0] GainReset   = 10'd256;
	localparam logic [7:0] ThreshReset = 8'd127;

	typedef logic [9:0] weight_t;

	localparam weight_t GRAY_W [0:2] = '{10'd307, 10'd614, 10'd102};

	localparam weight_t SEPIA_W [0:2][0:2] = '{
		'{10'd402, 10'd787, 10'd194},
		'{10'd357, 10'd702, 10'd172},
		'{10'd279, 10'd547, 10'd134}
	};

	typedef struct packed {
		mode_t      mode;
		logic [7:0] amount;
		logic [9:0] gain;
		logic [7:0] thresh;
	} cfg_t;

	typedef struct packed {
		mode_t                  mode;
		logic [2:0][7:0]        pix;
		logic [2:0][17:0]       gp;
		logic [2:0][2:0][17:0]  sp;
		logic [2:0][18:0]       ct;
	} s1_t;

	typedef struct packed {
		mode_t            mode;
		logic [2:0][7:0]  pix;
		logic [17:0]      gsum;
		logic [2:0][18:0] ssum;
		logic [2:0][7:0]  cc;
	} s2_t;

endpackage

/* hw/rtl/rppo_cfg.sv */
`timescale 1ns / 1ps

module rppo_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rppo_pkg::AddrW-1:0] paddr,
	input  logic [rppo_pkg::DataW-1:0] pwdata,
	output logic [rppo_pkg::DataW-1:0] prdata,
	output logic                       pready,
	output rppo_pkg::cfg_t             cfg
);
	import rppo_pkg::*;

	mode_t      mode_q;
	logic [7:0] amount_q;
	logic [9:0] gain_q;
	logic [7:0] thresh_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			amount_q <= '0;
			gain_q   <= GainReset;
			thresh_q <= ThreshReset;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:   mode_q   <= mode_t'(pwdata[2:0]);
				REG_AMOUNT: amount_q <= pwdata[7:0];
				REG_GAIN:   gain_q   <= pwdata[9:0];
				REG_THRESH: thresh_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE:   prdata = DataW'(mode_q);
			REG_AMOUNT: prdata = DataW'(amount_q);
			REG_GAIN:   prdata = DataW'(gain_q);
			REG_THRESH: prdata = DataW'(thresh_q);
		endcase
	end

	assign cfg.mode   = mode_q;
	assign cfg.amount = amount_q;
	assign cfg.gain   = gain_q;
	assign cfg.thresh = thresh_q;

endmodule

/* hw/rtl/rppo_mul.sv */
`timescale 1ns / 1ps

module rppo_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  rppo_pkg::cfg_t  cfg,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output logic            valid_s1,
	output rppo_pkg::s1_t   data_s1
);
	import rppo_pkg::*;

	s1_t               d;
	logic [2:0][7:0]   c;
	logic signed [7:0] dc;
	logic signed [18:0] dx;
	logic signed [18:0] gx;

	assign c = {blue, green, red};

	// per-channel constant and gain products
	always_comb begin
		d      = '0;
		dc     = '0;
		dx     = '0;
		gx     = 19'({1'b0, cfg.gain});
		d.mode = cfg.mode;
		d.pix  = c;
		for (int i = 0; i < 3; i++) begin
			d.gp[i] = 18'(GRAY_W[i]) * 18'(c[i]);
			for (int j = 0; j < 3; j++) begin
				d.sp[i][j] = 18'(SEPIA_W[i][j]) * 18'(c[j]);
			end
			dc      = $signed(c[i] ^ 8'h80);
			dx      = 19'(dc);
			d.ct[i] = dx * gx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			data_s1 <= d;
		end
	end

endmodule

/* hw/rtl/rppo_sum.sv */
`timescale 1ns / 1ps

module rppo_sum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  rppo_pkg::s1_t data_s1,
	output logic          valid_s2,
	output rppo_pkg::s2_t data_s2
);
	import rppo_pkg::*;

	s2_t                d;
	logic signed [18:0] t;
	logic signed [10:0] q;

	always_comb begin
		d      = '0;
		t      = '0;
		q      = '0;
		d.mode = data_s1.mode;
		d.pix  = data_s1.pix;
		d.gsum = 18'(data_s1.gp[0]) + 18'(data_s1.gp[1]) + 18'(data_s1.gp[2]);
		for (int i = 0; i < 3; i++) begin
			d.ssum[i] = 19'(data_s1.sp[i][0]) + 19'(data_s1.sp[i][1])
				+ 19'(data_s1.sp[i][2]);
			// floor divide by 256, recenter, clamp
			t = $signed(data_s1.ct[i]);
			q = 11'(t >>> 8) + 11'sd128;
			if (q < 0) begin
				d.cc[i] = 8'd0;
			end else if (q > 11'sd255) begin
				d.cc[i] = 8'd255;
			end else begin
				d.cc[i] = q[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= d;
		end
	end

endmodule

/* hw/rtl/rppo_fin.sv */
`timescale 1ns / 1ps

module rppo_fin (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	input  rppo_pkg::s2_t   data_s2,
	input  rppo_pkg::cfg_t  cfg,
	output logic            valid_s3,
	output logic [2:0][7:0] pix_s3
);
	import rppo_pkg::*;

	logic [2:0][7:0] o;
	logic [7:0]      gray;
	logic [7:0]      bin;
	logic [8:0]      up;
	logic [8:0]      sep;

	assign gray = data_s2.gsum[17:10];
	assign bin  = (gray > cfg.thresh) ? 8'd255 : 8'd0;

	always_comb begin
		o   = data_s2.pix;
		up  = '0;
		sep = '0;
		unique case (data_s2.mode)
			MODE_PASS: o = data_s2.pix;
			MODE_GRAY: o = {gray, gray, gray};
			MODE_NEG:  o = ~data_s2.pix;
			MODE_BRIGHT: begin
				for (int i = 0; i < 3; i++) begin
					up   = {1'b0, data_s2.pix[i]} + {1'b0, cfg.amount};
					o[i] = up[8] ? 8'd255 : up[7:0];
				end
			end
			MODE_DARK: begin
				for (int i = 0; i < 3; i++) begin
					o[i] = (data_s2.pix[i] > cfg.amount) ?
						data_s2.pix[i] - cfg.amount : 8'd0;
				end
			end
			MODE_CONTRAST: o = data_s2.cc;
			MODE_BINARY:   o = {bin, bin, bin};
			MODE_SEPIA: begin
				for (int i = 0; i < 3; i++) begin
					sep  = data_s2.ssum[i][18:10];
					o[i] = sep[8] ? 8'd255 : sep[7:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			pix_s3 <= o;
		end
	end

endmodule

/* hw/rtl/rgb_pixel_point_operation_top.sv */
`timescale 1ns / 1ps

// channel  | handshake                          | payload
// ---------+------------------------------------+----------------------------------
// pixel in | start, busy                        | red_in, green_in, blue_in
// pixel out| done (one-cycle strobe)            | red_out, green_out, blue_out
// config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// one pixel per clock; busy is never raised
// registered stages in order: product stage, sum and contrast clamp stage, mode select stage
// each result is shown for one cycle with done
// arst_n clears the valid bits and restores register defaults; no clearing pass
// the receiver cannot stall, so the pipeline never holds

module rgb_pixel_point_operation_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [7:0]                 red_in,
	input  logic [7:0]                 green_in,
	input  logic [7:0]                 blue_in,
	output logic                       done,
	output logic [7:0]                 red_out,
	output logic [7:0]                 green_out,
	output logic [7:0]                 blue_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rppo_pkg::AddrW-1:0] paddr,
	input  logic [rppo_pkg::DataW-1:0] pwdata,
	output logic [rppo_pkg::DataW-1:0] prdata,
	output logic                       pready
);
	import rppo_pkg::*;

	cfg_t            cfg;
	logic            in_vld;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	s1_t             data_s1;
	s2_t             data_s2;
	logic [2:0][7:0] pix_s3;

	assign busy   = 1'b0;
	assign in_vld = start && !busy;

	rppo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rppo_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (in_vld),
		.cfg      (cfg),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	rppo_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	rppo_fin u_fin (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.pix_s3   (pix_s3)
	);

	assign done      = valid_s3;
	assign red_out   = pix_s3[0];
	assign green_out = pix_s3[1];
	assign blue_out  = pix_s3[2];

	// every accepted beat comes out as a done result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted pixel did not produce a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching accepted pixel");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("stage valid bits out of step");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import rppo_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int Latency    = 3;
	localparam int RandPhases = 37;
	localparam int PhaseLen   = 50;

	localparam int GRAY_Q10 [3] = '{307, 614, 102};
	localparam int SEPIA_Q10 [3][3] = '{
		'{402, 787, 194},
		'{357, 702, 172},
		'{279, 547, 134}
	};

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	class pixel_scoreboard;
		rgb_t       expected_q [$];
		mode_t      mode;
		logic [7:0] amount;
		logic [9:0] gain;
		logic [7:0] thresh;
		int         errors;

		function new();
			mode   = MODE_PASS;
			amount = 8'd0;
			gain   = GainReset;
			thresh = ThreshReset;
			errors = 0;
		endfunction

		function void report_mismatch(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_MODE:   mode   = mode_t'(data[2:0]);
				REG_AMOUNT: amount = data[7:0];
				REG_GAIN:   gain   = data[9:0];
				REG_THRESH: thresh = data[7:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_MODE:   return 32'(mode);
				REG_AMOUNT: return 32'(amount);
				REG_GAIN:   return 32'(gain);
				default:    return 32'(thresh);
			endcase
		endfunction

		function int gray_of(logic [7:0] c [3]);
			return (GRAY_Q10[0] * int'(c[0]) + GRAY_Q10[1] * int'(c[1]) +
				GRAY_Q10[2] * int'(c[2])) >> 10;
		endfunction

		function rgb_t transform(rgb_t p);
			logic [7:0] c [3];
			logic [7:0] o [3];
			int         s;
			int         t;
			c[0] = p.r;
			c[1] = p.g;
			c[2] = p.b;
			for (int i = 0; i < 3; i++) begin
				case (mode)
					MODE_GRAY:   o[i] = 8'(gray_of(c));
					MODE_NEG:    o[i] = 8'd255 - c[i];
					MODE_BRIGHT: begin
						s = int'(c[i]) + int'(amount);
						o[i] = (s > 255) ? 8'd255 : 8'(s);
					end
					MODE_DARK:   o[i] = (c[i] > amount) ? c[i] - amount : 8'd0;
					MODE_CONTRAST: begin
						t = (int'(c[i]) - 128) * int'(gain);
						s = (t >>> 8) + 128;
						o[i] = (s < 0) ? 8'd0 : (s > 255) ? 8'd255 : 8'(s);
					end
					MODE_BINARY: o[i] = (gray_of(c) > int'(thresh)) ? 8'd255 : 8'd0;
					MODE_SEPIA: begin
						s = (SEPIA_Q10[i][0] * int'(c[0]) + SEPIA_Q10[i][1] * int'(c[1]) +
							SEPIA_Q10[i][2] * int'(c[2])) >> 10;
						o[i] = (s > 255) ? 8'd255 : 8'(s);
					end
					default:     o[i] = c[i];
				endcase
			end
			return '{r: o[0], g: o[1], b: o[2]};
		endfunction

		function void note_pixel(rgb_t p);
			expected_q.push_back(transform(p));
		endfunction

		function void check_pixel(rgb_t got);
			rgb_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %h", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.r !== want.r)
				report_mismatch($sformatf("red got %h want %h", got.r, want.r));
			if (got.g !== want.g)
				report_mismatch($sformatf("green got %h want %h", got.g, want.g));
			if (got.b !== want.b)
				report_mismatch($sformatf("blue got %h want %h", got.b, want.b));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [7:0]       red_in;
	logic [7:0]       green_in;
	logic [7:0]       blue_in;
	logic             done;
	logic [7:0]       red_out;
	logic [7:0]       green_out;
	logic [7:0]       blue_out;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	pixel_scoreboard sb;

	rgb_pixel_point_operation_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel('{r: red_out, g: green_out, b: blue_out});
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx) << 2;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, data);
	endtask

	task automatic read_reg(reg_idx_t idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= AddrW'(idx) << 2;
		pwdata  <= '0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx))
			sb.report_mismatch($sformatf("register %s read %h want %h", idx.name(),
				prdata, sb.reg_value(idx)));
	endtask

	task automatic read_all_regs();
		read_reg(REG_MODE);
		read_reg(REG_AMOUNT);
		read_reg(REG_GAIN);
		read_reg(REG_THRESH);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// upper bits beyond the register width must be dropped
	function automatic logic [31:0] with_noise(logic [31:0] v, int w);
		if ($urandom_range(0, 3) == 0)
			return v | ($urandom() << w);
		return v;
	endfunction

	function automatic logic [7:0] pick_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd128;
			3:       return 8'd127;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic send_pixel(rgb_t p, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		red_in   <= p.r;
		green_in <= p.g;
		blue_in  <= p.b;
		do @(posedge clk); while (busy);
		sb.note_pixel(p);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(mode_t m, logic [7:0] amt, logic [9:0] gn, logic [7:0] th,
		int n, bit directed);
		rgb_t p;
		bit   burst;
		drain();
		write_reg(REG_MODE, with_noise(32'(m), 3));
		write_reg(REG_AMOUNT, with_noise(32'(amt), 8));
		write_reg(REG_GAIN, with_noise(32'(gn), 10));
		write_reg(REG_THRESH, with_noise(32'(th), 8));
		read_all_regs();
		burst = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < n; k++) begin
			if (directed) begin
				case (k)
					0:       p = '{r: 8'd0, g: 8'd0, b: 8'd0};
					1:       p = '{r: 8'd255, g: 8'd255, b: 8'd255};
					default: p = '{r: 8'd255, g: 8'd0, b: 8'd128};
				endcase
			end else begin
				p = '{r: pick_chan(), g: pick_chan(), b: pick_chan()};
			end
			send_pixel(p, burst);
		end
	endtask

	initial begin
		mode_t      m;
		logic [7:0] amt;
		logic [9:0] gn;
		logic [7:0] th;
		sb = new();
		arst_n   <= 1'b0;
		start    <= 1'b0;
		red_in   <= 8'd0;
		green_in <= 8'd0;
		blue_in  <= 8'd0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all_regs();

		// extremes in every mode, contrast at full gain to hit both clamps
		for (int i = 0; i < 8; i++)
			run_phase(mode_t'(i), 8'd100, 10'd1023, 8'd127, 3, 1'b1);

		for (int i = 0; i < RandPhases; i++) begin
			m = (i < 8) ? mode_t'(i) : mode_t'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0:       amt = 8'd0;
				1:       amt = 8'd255;
				default: amt = 8'($urandom());
			endcase
			case ($urandom_range(0, 5))
				0:       gn = 10'd0;
				1:       gn = 10'd1023;
				2:       gn = 10'd154;
				3:       gn = 10'd307;
				4:       gn = 10'd256;
				default: gn = 10'($urandom());
			endcase
			case ($urandom_range(0, 3))
				0:       th = 8'd0;
				1:       th = 8'd255;
				default: th = 8'($urandom());
			endcase
			run_phase(m, amt, gn, th, PhaseLen, 1'b0);
		end

		drain();
		repeat (Latency + 5) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
